[rtl/core/wles_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wles_pkg
// Shared sizes, day codes, day match function, table entry layout and
// sequencer states of the weekly light event scheduler.
// ----------------------------------------------------------------------------
package wles_pkg;

   localparam int EVENT_SLOTS = 64;
   localparam int ADDR_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

   localparam logic [3:0] DAY_SUNDAY   = 4'd0;
   localparam logic [3:0] DAY_SATURDAY = 4'd6;
   localparam logic [3:0] DAY_EVERY    = 4'd7;
   localparam logic [3:0] DAY_WEEKEND  = 4'd8;

   localparam logic KIND_SCHEDULE = 1'b0;
   localparam logic KIND_TICK     = 1'b1;

   typedef struct packed {
      logic [7:0] light;
      logic       action;
   } cmd_type;

   typedef struct packed {
      logic [10:0] minute;
      logic [3:0]  day;
      cmd_type     cmd;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   function automatic logic day_match(input logic [3:0] today, input logic [3:0] code);
      return (code == DAY_EVERY) ||
             ((code == DAY_WEEKEND) && ((today == DAY_SATURDAY) || (today == DAY_SUNDAY))) ||
             (code == today);
   endfunction

endpackage

[rtl/core/wles_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wles_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wles_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/weekly_light_event_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_light_event_scheduler
// Table of scheduled light events, filled by schedule words and scanned on
// every tick word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries schedule and tick words; req_tuser selects the kind
//   (0 schedule, 1 tick). A schedule word is written to the next free slot
//   of the event RAM; it is dropped when the table is full.
//   A tick word starts a scan of the used slots, one RAM read per cycle
//   unless the scan stalls, and each slot whose day code and minute match
//   gives one command word on rsp_*; rsp_tlast marks the final command of
//   the tick. A tick with no match gives no word.
//   A tick keeps the block busy (req_tready low) through the scan and flush
//   states over the single RAM read port; a schedule word leaves it idle.
//   Each matching command is held back one hit so that the final one can be
//   marked, and leaves through an output register, so the next item is
//   taken while the last command still waits. While rsp_tready is low
//   and a second hit needs the output register, the scan stops in place.
//   Reset empties the table at once (fill count cleared) and drops any
//   pending command.
// ----------------------------------------------------------------------------
module weekly_light_event_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // light_id[7:0], action[8], day[12:9], minute[23:13]
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_light[7:0], out_action[8], zero[15:9]
   output logic        rsp_tlast
);

   localparam int AW = wles_pkg::ADDR_W;
   localparam int CW = wles_pkg::CNT_W;

   wles_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       addr_ff, addr_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                pend_valid_ff, pend_valid_in;
   wles_pkg::cmd_type   pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wles_pkg::cmd_type   rsp_cmd_ff, rsp_cmd_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [3:0]          tick_day_ff, tick_day_in;
   logic [10:0]         tick_min_ff, tick_min_in;

   wles_pkg::entry_type req_entry;
   wles_pkg::entry_type ram_rdata;
   logic                req_accept;
   logic                out_free;
   logic                hit;
   logic                stall;
   logic                issue;
   logic                scan_done;
   logic                ram_we;
   logic                push;
   logic                push_last;
   wles_pkg::cmd_type   push_cmd;

   assign req_entry.cmd.light  = req_tdata[7:0];
   assign req_entry.cmd.action = req_tdata[8];
   assign req_entry.day        = req_tdata[12:9];
   assign req_entry.minute     = req_tdata[23:13];

   assign req_tready = (state_ff == wles_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hit = rd_pend_ff &&
                wles_pkg::day_match(tick_day_ff, ram_rdata.day) &&
                (ram_rdata.minute == tick_min_ff);
   assign stall     = hit && pend_valid_ff && !out_free;
   assign issue     = (state_ff == wles_pkg::ST_SCAN) && !stall && (addr_ff < fill_ff);
   assign scan_done = (addr_ff == fill_ff) && !rd_pend_ff;
   assign ram_we    = req_accept && (req_tuser == wles_pkg::KIND_SCHEDULE) &&
                      (fill_ff < CW'(wles_pkg::EVENT_SLOTS));

   wles_ram #(
      .WIDTH($bits(wles_pkg::entry_type)),
      .DEPTH(wles_pkg::EVENT_SLOTS)
   ) u_event_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(fill_ff[AW-1:0]),
      .wdata(req_entry),
      .re   (issue),
      .raddr(addr_ff[AW-1:0]),
      .rdata(ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wles_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser == wles_pkg::KIND_TICK)) begin
               state_in = wles_pkg::ST_SCAN;
            end
         end
         wles_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = wles_pkg::ST_FLUSH;
            end
         end
         wles_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = wles_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wles_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and output control
   always_comb begin
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      rd_pend_in    = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      tick_day_in   = tick_day_ff;
      tick_min_in   = tick_min_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      push_cmd      = pend_ff;
      case (state_ff)
         wles_pkg::ST_IDLE: begin
            if (ram_we) begin
               fill_in = fill_ff + CW'(1);
            end
            if (req_accept && (req_tuser == wles_pkg::KIND_TICK)) begin
               addr_in     = '0;
               tick_day_in = req_entry.day;
               tick_min_in = req_entry.minute;
            end
         end
         wles_pkg::ST_SCAN: begin
            rd_pend_in = stall ? rd_pend_ff : issue;
            if (issue) begin
               addr_in = addr_ff + CW'(1);
            end
            // release the previous hit, keep the new one back for tlast
            if (hit && !stall) begin
               push          = pend_valid_ff;
               pend_in       = ram_rdata.cmd;
               pend_valid_in = 1'b1;
            end
         end
         wles_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = push_cmd;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wles_pkg::ST_IDLE;
         fill_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rd_pend_ff    <= rd_pend_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      pend_ff     <= pend_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_last_ff <= rsp_last_in;
      tick_day_ff <= tick_day_in;
      tick_min_ff <= tick_min_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cmd_ff.action, rsp_cmd_ff.light};
   assign rsp_tlast  = rsp_last_ff;

endmodule
